/* hw/rtl/http_status_line_parser_assert.svh */
// ---------------------------------------------------------------------------
// status line parser assertion macros
// shared concurrent assertion forms for the parser checkers
// ---------------------------------------------------------------------------
`ifndef HTTP_STATUS_LINE_PARSER_ASSERT_SVH
`define HTTP_STATUS_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define HSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsp assertion failed");

// next-cycle implication
`define HSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsp assertion failed");

`endif

/* hw/rtl/hsp_pkg.sv */
// ---------------------------------------------------------------------------
// hsp_pkg
// types and constants of the status line parser
// ---------------------------------------------------------------------------
package hsp_pkg;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_REASON = 2'd1;
    localparam logic [1:0] EV_DONE   = 2'd2;
    localparam logic [1:0] EV_ERR    = 2'd3;

    localparam logic [3:0] POS_LEAD_LAST = 4'd4;
    localparam logic [3:0] POS_MAJOR     = 4'd5;
    localparam logic [3:0] POS_DOT       = 4'd6;
    localparam logic [3:0] POS_MINOR     = 4'd7;
    localparam logic [3:0] POS_SPACE     = 4'd8;
    localparam logic [3:0] POS_CODE      = 4'd9;
    localparam logic [3:0] POS_REASON    = 4'd10;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] CODE_DIGITS = 3'd3;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] reason_byte;
        logic [3:0] major_digit;
        logic [3:0] minor_digit;
        logic [9:0] code_value;
        logic       last;
    } t_result;

    function automatic logic [7:0] lead_byte(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/hsp_core.sv */
// ---------------------------------------------------------------------------
// hsp_core
// line state and per-byte decode, up to two results per request
// ---------------------------------------------------------------------------
module hsp_core
    import hsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_enable,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    output logic [1:0] o_count,
    output t_result    o_res0,
    output t_result    o_res1
);

    typedef struct packed {
        logic [3:0] pos;
        logic [3:0] major;
        logic [3:0] minor;
        logic [9:0] acc;
        logic [2:0] dcnt;
        logic       crp;
        logic       err;
        logic       fin;
    } t_state;

    typedef struct packed {
        t_state s;
        logic   emit;
    } t_feed;

    localparam t_state STATE_CLEAR = '0;

    t_state r_st;
    t_state n_st;

    function automatic t_feed feed(input t_state s_in, input logic [7:0] b);
        t_feed      f;
        logic       dig;
        logic [7:0] diff;
        f      = '{s: s_in, emit: 1'b0};
        dig    = (b >= CH_ZERO) && (b <= CH_NINE);
        diff   = b - CH_ZERO;
        if (!s_in.err) begin
            case (s_in.pos) inside
                [4'd0:POS_LEAD_LAST]: begin
                    if (b == lead_byte(s_in.pos[2:0])) f.s.pos = s_in.pos + 4'd1;
                    else f.s.err = 1'b1;
                end
                POS_MAJOR: begin
                    if (dig) begin
                        f.s.major = diff[3:0];
                        f.s.pos   = POS_DOT;
                    end else f.s.err = 1'b1;
                end
                POS_DOT: begin
                    if (b == CH_DOT) f.s.pos = POS_MINOR;
                    else f.s.err = 1'b1;
                end
                POS_MINOR: begin
                    if (dig) begin
                        f.s.minor = diff[3:0];
                        f.s.pos   = POS_SPACE;
                    end else f.s.err = 1'b1;
                end
                POS_SPACE: begin
                    if (b == CH_SPACE) f.s.pos = POS_CODE;
                    else f.s.err = 1'b1;
                end
                POS_CODE: begin
                    if (dig && (s_in.dcnt < CODE_DIGITS)) begin
                        f.s.acc  = (s_in.acc << 3) + (s_in.acc << 1) + {6'd0, diff[3:0]};
                        f.s.dcnt = s_in.dcnt + 3'd1;
                    end else if ((b == CH_SPACE) && (s_in.dcnt == CODE_DIGITS)) begin
                        f.s.pos = POS_REASON;
                    end else f.s.err = 1'b1;
                end
                POS_REASON: f.emit = 1'b1;
                default:    f.s.err = 1'b1;
            endcase
        end
        return f;
    endfunction

    always_comb begin
        t_feed      fa;
        t_feed      fb;
        t_result    ra;
        t_result    rb;
        logic       ea;
        logic       eb;
        n_st    = r_st;
        o_count = 2'd0;
        o_res0  = '0;
        o_res1  = '0;
        ra      = '0;
        rb      = '0;
        ea      = 1'b0;
        eb      = 1'b0;
        fa      = '{s: r_st, emit: 1'b0};
        fb      = '{s: r_st, emit: 1'b0};
        if (i_func) begin
            n_st = STATE_CLEAR;
        end else if (!r_st.fin) begin
            if (r_st.crp && (i_data_byte == CH_LF)) begin
                n_st     = r_st;
                n_st.crp = 1'b0;
                n_st.fin = 1'b1;
                if (!r_st.err && (r_st.pos == POS_REASON)) begin
                    o_res0.event_res   = EV_DONE;
                    o_res0.major_digit = r_st.major;
                    o_res0.minor_digit = r_st.minor;
                    o_res0.code_value  = r_st.acc;
                end else begin
                    o_res0.event_res = EV_ERR;
                end
                o_res0.last = 1'b1;
                o_count     = 2'd1;
            end else begin
                fa       = '{s: r_st, emit: 1'b0};
                fa.s.crp = 1'b0;
                if (r_st.crp) fa = feed(fa.s, CH_CR);
                ea = fa.emit;
                ra.event_res   = EV_REASON;
                ra.reason_byte = CH_CR;
                if (i_data_byte == CH_CR) begin
                    fb       = '{s: fa.s, emit: 1'b0};
                    fb.s.crp = 1'b1;
                end else begin
                    fb = feed(fa.s, i_data_byte);
                end
                eb = fb.emit;
                rb.event_res   = EV_REASON;
                rb.reason_byte = i_data_byte;
                n_st = fb.s;
                if (ea && eb) begin
                    o_res0      = ra;
                    o_res1      = rb;
                    o_res1.last = 1'b1;
                    o_count     = 2'd2;
                end else if (ea) begin
                    o_res0      = ra;
                    o_res0.last = 1'b1;
                    o_count     = 2'd1;
                end else if (eb) begin
                    o_res0      = rb;
                    o_res0.last = 1'b1;
                    o_count     = 2'd1;
                end
            end
        end
        if (!i_enable) begin
            n_st    = r_st;
            o_count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_CLEAR;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

/* hw/rtl/http_status_line_parser.sv */
// ---------------------------------------------------------------------------
// http_status_line_parser: response status line checker, one byte per request
// a request is held in the input register, then decoded and its results written to the result queue
// throughput: 1 request per cycle while the 4-entry result queue has room for two results
// reset: synchronous active low, clears line state and empties the queue
// ---------------------------------------------------------------------------
module http_status_line_parser
    import hsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_event_res,
    output logic [7:0] o_reason_byte,
    output logic [3:0] o_major_digit,
    output logic [3:0] o_minor_digit,
    output logic [9:0] o_code_value,
    output logic       o_last
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(QUEUE_DEPTH - 2);

    logic          r_in_valid;
    logic          r_in_func;
    logic [7:0]    r_in_byte;
    t_result       r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic          process;
    logic          pop;
    logic [1:0]    push_n;
    t_result       res0;
    t_result       res1;
    t_result       head;
    logic [PW-1:0] wr_next;

    assign process    = r_in_valid && (r_count <= ROOM_LIMIT);
    assign o_in_stall = r_in_valid && !process;
    assign pop        = o_out_valid && !i_out_stall;

    hsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (process),
        .i_func      (r_in_func),
        .i_data_byte (r_in_byte),
        .o_count     (push_n),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wr_next = ptr_inc(r_wr_ptr);
    assign n_count = r_count + CW'(push_n) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (push_n == 2'd1) r_wr_ptr <= wr_next;
            else if (push_n == 2'd2) r_wr_ptr <= ptr_inc(wr_next);
            if (pop) r_rd_ptr <= ptr_inc(r_rd_ptr);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_func <= i_func;
            r_in_byte <= i_data_byte;
        end
        if (push_n != 2'd0) r_mem[r_wr_ptr] <= res0;
        if (push_n == 2'd2) r_mem[wr_next] <= res1;
    end

    assign head          = r_mem[r_rd_ptr];
    assign o_out_valid   = (r_count != '0);
    assign o_event_res   = head.event_res;
    assign o_reason_byte = head.reason_byte;
    assign o_major_digit = head.major_digit;
    assign o_minor_digit = head.minor_digit;
    assign o_code_value  = head.code_value;
    assign o_last        = head.last;

endmodule

/* hw/rtl/hsp_checker.sv */
// ---------------------------------------------------------------------------
// hsp_checker
// port-level checks on the parser result channel
// ---------------------------------------------------------------------------
`include "http_status_line_parser_assert.svh"

module hsp_checker
    import hsp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_event_res,
    input logic [7:0] o_reason_byte,
    input logic [3:0] o_major_digit,
    input logic [3:0] o_minor_digit,
    input logic [9:0] o_code_value,
    input logic       o_last
);

    `HSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_event_res) && $stable(o_reason_byte) && $stable(o_code_value) && $stable(o_last))
    `HSP_ASSERT_IMPL(a_no_empty_event, i_clk, i_rst_n, o_out_valid, o_event_res != EV_NONE)
    `HSP_ASSERT_IMPL(a_report_is_last, i_clk, i_rst_n, o_out_valid && (o_event_res == EV_DONE || o_event_res == EV_ERR), o_last)
    `HSP_ASSERT_IMPL(a_fields_zero, i_clk, i_rst_n, o_out_valid && o_event_res != EV_DONE, o_major_digit == 4'd0 && o_minor_digit == 4'd0 && o_code_value == 10'd0)

endmodule

bind http_status_line_parser hsp_checker u_hsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_event_res   (o_event_res),
    .o_reason_byte (o_reason_byte),
    .o_major_digit (o_major_digit),
    .o_minor_digit (o_minor_digit),
    .o_code_value  (o_code_value),
    .o_last        (o_last)
);
